FILE: rtl/base64_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// base64_stream_decoder_defines - assertion macros
// Shared assertion forms for the base64 stream decoder. Each expects clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define B64SD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define B64SD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/b64sd_pkg.sv
// ----------------------------------------------------------------------------
// b64sd_pkg - base64 stream decoder package
// Packet type passed from the character front end through the queue to the
// byte serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b64sd_pkg;

  // Up to three decoded bytes, first byte in word[23:16].
  // n_bytes == 0 with last set is a bare end marker.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  n_bytes;
    logic        last;
  } pkt_t;

endpackage

`default_nettype wire

FILE: rtl/b64sd_char_if.sv
// ----------------------------------------------------------------------------
// b64sd_char_if - character channel
// Valid/ready channel carrying one encoded ASCII character per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface b64sd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

`default_nettype wire

FILE: rtl/b64sd_byte_if.sv
// ----------------------------------------------------------------------------
// b64sd_byte_if - decoded byte channel
// Valid/ready channel carrying one decoded byte or end marker per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface b64sd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/b64sd_front.sv
// ----------------------------------------------------------------------------
// b64sd_front - character classifier and group builder
// Maps each character to a sextet, gathers groups of four and turns each
// accepted character into at most one byte packet for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64sd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       char_code,
  input  wire logic             end_of_string,
  input  wire logic             q_full,
  output logic                  push,
  output b64sd_pkg::pkt_t       pkt
);
  import b64sd_pkg::*;

  logic [17:0] group_r, group_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        halted_r, halted_nxt;

  logic        accept;
  logic        is_alpha;
  logic [5:0]  sext;
  logic [17:0] group_app;
  logic        full_emit;
  logic [17:0] flush_grp;
  logic [1:0]  flush_cnt;
  logic [23:0] flush_word;
  logic [1:0]  flush_n;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Standard alphabet lookup
  always_comb begin
    is_alpha = 1'b1;
    sext     = 6'd0;
    if (char_code >= 8'h41 && char_code <= 8'h5A) begin
      sext = 6'(char_code - 8'h41);
    end else if (char_code >= 8'h61 && char_code <= 8'h7A) begin
      sext = 6'(char_code - 8'h47);
    end else if (char_code >= 8'h30 && char_code <= 8'h39) begin
      sext = 6'(char_code + 8'h04);
    end else if (char_code == 8'h2B) begin
      sext = 6'd62;
    end else if (char_code == 8'h2F) begin
      sext = 6'd63;
    end else begin
      is_alpha = 1'b0;
    end
  end

  assign group_app = {group_r[11:0], sext};
  assign full_emit = !halted_r && is_alpha && (count_r == 2'd3);

  // At most one flush per character: on a halting code, or at end of string
  // after appending the character.
  always_comb begin
    flush_grp = 18'd0;
    flush_cnt = 2'd0;
    if (!halted_r && !is_alpha) begin
      flush_grp = group_r;
      flush_cnt = count_r;
    end else if (!halted_r && is_alpha && count_r != 2'd3 && end_of_string) begin
      flush_grp = group_app;
      flush_cnt = 2'(count_r + 2'd1);
    end
  end

  always_comb begin
    case (flush_cnt)
      2'd2: begin
        flush_word = {flush_grp[11:0], 12'h000};
        flush_n    = 2'd1;
      end
      2'd3: begin
        flush_word = {flush_grp, 6'h00};
        flush_n    = 2'd2;
      end
      default: begin
        flush_word = 24'h000000;
        flush_n    = 2'd0;
      end
    endcase
  end

  always_comb begin
    pkt.word    = full_emit ? {group_r, sext} : flush_word;
    pkt.n_bytes = full_emit ? 2'd3 : flush_n;
    pkt.last    = end_of_string;
    push        = accept && (pkt.n_bytes != 2'd0 || end_of_string);
  end

  always_comb begin
    group_nxt  = group_r;
    count_nxt  = count_r;
    halted_nxt = halted_r;
    if (accept) begin
      if (end_of_string) begin
        group_nxt  = 18'd0;
        count_nxt  = 2'd0;
        halted_nxt = 1'b0;
      end else if (!halted_r) begin
        if (!is_alpha) begin
          group_nxt  = 18'd0;
          count_nxt  = 2'd0;
          halted_nxt = 1'b1;
        end else if (full_emit) begin
          group_nxt = 18'd0;
          count_nxt = 2'd0;
        end else begin
          group_nxt = group_app;
          count_nxt = 2'(count_r + 2'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r  <= 18'd0;
      count_r  <= 2'd0;
      halted_r <= 1'b0;
    end else begin
      group_r  <= group_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b64sd_fifo.sv
// ----------------------------------------------------------------------------
// b64sd_fifo - packet queue
// Small flop-based queue decoupling the front end from the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_decoder_defines.svh"

module b64sd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire b64sd_pkg::pkt_t  wr_pkt,
  input  wire logic             pop,
  output b64sd_pkg::pkt_t       head,
  output logic                  full,
  output logic                  empty
);
  import b64sd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pkt_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == CW'(0));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? AW'(0) : AW'(wr_ptr_r + AW'(1));
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? AW'(0) : AW'(rd_ptr_r + AW'(1));
    end
    cnt_nxt = CW'(cnt_r + CW'(push) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `B64SD_ASSERT_IMPL(a_fifo_no_overflow, push, !full, "push into full packet queue")
  `B64SD_ASSERT_IMPL(a_fifo_no_underflow, pop, !empty, "pop from empty packet queue")

endmodule

`default_nettype wire

FILE: rtl/b64sd_back.sv
// ----------------------------------------------------------------------------
// b64sd_back - byte serializer
// Splits queued packets into one result word per cycle behind an output
// register, while a packet is available and the receiver is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_decoder_defines.svh"

module b64sd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire b64sd_pkg::pkt_t  head,
  input  wire logic             q_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            data_byte,
  output logic                  byte_valid,
  output logic                  last
);
  import b64sd_pkg::*;

  pkt_t       cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] data_r, data_nxt;
  logic       bv_r, bv_nxt;
  logic       last_r, last_nxt;

  pkt_t       src;
  logic       src_ok;
  logic [1:0] idx;
  logic       final_word;
  logic [7:0] sel_byte;
  logic       load;

  assign src        = busy_r ? cur_r : head;
  assign src_ok     = busy_r || !q_empty;
  assign idx        = busy_r ? idx_r : 2'd0;
  assign final_word = (src.n_bytes == 2'd0) || (idx == 2'(src.n_bytes - 2'd1));
  assign load       = src_ok && (!vld_r || out_ready);
  assign pop        = load && !busy_r;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = src.word[23:16];
      2'd1:    sel_byte = src.word[15:8];
      default: sel_byte = src.word[7:0];
    endcase
  end

  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    vld_nxt  = vld_r;
    data_nxt = data_r;
    bv_nxt   = bv_r;
    last_nxt = last_r;
    if (load) begin
      vld_nxt  = 1'b1;
      data_nxt = (src.n_bytes == 2'd0) ? 8'h00 : sel_byte;
      bv_nxt   = (src.n_bytes != 2'd0);
      last_nxt = src.last && final_word;
      if (busy_r) begin
        // advance within the held packet, release it after its last word
        if (final_word) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = 2'(idx_r + 2'd1);
        end
      end else if (!final_word) begin
        cur_nxt  = head;
        idx_nxt  = 2'd1;
        busy_nxt = 1'b1;
      end
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    data_r <= data_nxt;
    bv_r   <= bv_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 2'd0;
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  assign out_valid  = vld_r;
  assign data_byte  = data_r;
  assign byte_valid = bv_r;
  assign last       = last_r;

  `B64SD_ASSERT_IMPL(a_back_busy_multi, busy_r, cur_r.n_bytes >= 2'd2 && idx_r != 2'd0 && idx_r < cur_r.n_bytes, "held packet index out of range")
  `B64SD_ASSERT_NEXT(a_back_hold_split, load && !busy_r && !final_word, busy_r, "multi-word packet not held")

endmodule

`default_nettype wire

FILE: rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder - streaming base64 decoder, one character per word
// Path: a taken character's packet is written into the packet queue, and its
// first result word is then loaded into the output register.
// Throughput: one character per cycle in; one result word per cycle out while
// the receiver is ready. Input stalls only while the packet queue is full.
// Reset: synchronous rst_n clears group state, packet queue and output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  b64sd_char_if.sink     in_ch,
  b64sd_byte_if.source   out_ch
);
  import b64sd_pkg::*;

  pkt_t fr_pkt;
  pkt_t q_head;
  logic fr_push;
  logic q_full;
  logic q_empty;
  logic bk_pop;

  b64sd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .char_code     (in_ch.char_code),
    .end_of_string (in_ch.end_of_string),
    .q_full        (q_full),
    .push          (fr_push),
    .pkt           (fr_pkt)
  );

  b64sd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fr_push),
    .wr_pkt (fr_pkt),
    .pop    (bk_pop),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  b64sd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .pop        (bk_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .data_byte  (out_ch.data_byte),
    .byte_valid (out_ch.byte_valid),
    .last       (out_ch.last)
  );

endmodule

`default_nettype wire

FILE: tb/tb_base64_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder - self-checking bench for the base64 stream decoder
// Feeds directed and random character strings through the input channel,
// decodes them in a behavioral model and compares every result word in order,
// under phases of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------

module tb_base64_stream_decoder;

  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 16;
  localparam int         MAX_REPORTS    = 10;
  localparam logic [7:0] PAD_CHAR       = 8'h3D;
  localparam logic [7:0] PLUS_CHAR      = 8'h2B;
  localparam logic [7:0] SLASH_CHAR     = 8'h2F;
  localparam logic [6:0] NO_SEXTET      = 7'h40;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } char_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } byte_word_t;

  logic clk;
  logic rst_n;

  b64sd_char_if in_if ();
  b64sd_byte_if out_if ();

  base64_stream_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  char_word_t  pending_chars[$];
  byte_word_t  expected_bytes[$];
  byte_word_t  step_bytes[$];
  char_word_t  next_char;

  // decoder model state
  logic [17:0] dec_group;
  logic [1:0]  dec_count;
  logic        dec_halted;

  int          tx_idle_pct;
  int          rx_stall_pct;
  int          mismatch_count;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Emit k-1 bytes of a partial group of k sextets, then clear the group.
  function automatic void flush_partial();
    logic [23:0] w24;
    byte_word_t  bw;
    int          j;
    w24 = {6'd0, dec_group} << (6 * (4 - dec_count));
    for (j = 0; j + 1 < dec_count; j++) begin
      bw.data_byte  = w24[23 - 8 * j -: 8];
      bw.byte_valid = 1'b1;
      bw.last       = 1'b0;
      step_bytes = {step_bytes, bw};
    end
    dec_group = '0;
    dec_count = '0;
  endfunction

  function automatic void predict_bytes(input logic [7:0] c, input logic eos);
    logic [6:0]  sx;
    logic [23:0] w24;
    byte_word_t  bw;
    int          j;
    step_bytes.delete();
    if (!dec_halted) begin
      if (c >= 8'h41 && c <= 8'h5A) sx = 7'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7A) sx = 7'(c - 8'h61 + 8'd26);
      else if (c >= 8'h30 && c <= 8'h39) sx = 7'(c - 8'h30 + 8'd52);
      else if (c == PLUS_CHAR) sx = 7'd62;
      else if (c == SLASH_CHAR) sx = 7'd63;
      else sx = NO_SEXTET;

      if (sx == NO_SEXTET) begin
        dec_halted = 1'b1;
        flush_partial();
      end else if (dec_count == 2'd3) begin
        w24 = {dec_group, sx[5:0]};
        for (j = 0; j < 3; j++) begin
          bw.data_byte  = w24[23 - 8 * j -: 8];
          bw.byte_valid = 1'b1;
          bw.last       = 1'b0;
          step_bytes = {step_bytes, bw};
        end
        dec_group = '0;
        dec_count = '0;
      end else begin
        dec_group = {dec_group[11:0], sx[5:0]};
        dec_count = dec_count + 2'd1;
      end
    end
    if (eos) begin
      flush_partial();
      if (step_bytes.size() == 0) begin
        bw = '0;
        step_bytes = {step_bytes, bw};
      end
      step_bytes[step_bytes.size() - 1].last = 1'b1;
      dec_halted = 1'b0;
    end
    foreach (step_bytes[i]) expected_bytes = {expected_bytes, step_bytes[i]};
  endfunction

  function automatic logic [7:0] char_of_sextet(input logic [5:0] s);
    if (s < 6'd26) return 8'h41 + s;
    if (s < 6'd52) return 8'h61 + s - 8'd26;
    if (s < 6'd62) return 8'h30 + s - 8'd52;
    if (s == 6'd62) return PLUS_CHAR;
    return SLASH_CHAR;
  endfunction

  function automatic logic [7:0] invalid_char();
    case ($urandom_range(3))
      0: return PAD_CHAR;
      1: return 8'($urandom_range(128, 255));
      2: return 8'($urandom_range(0, 42));
      default: return 8'($urandom_range(58, 64));
    endcase
  endfunction

  task automatic push_char(input logic [7:0] c, input logic eos);
    char_word_t cw;
    cw.char_code     = c;
    cw.end_of_string = eos;
    pending_chars = {pending_chars, cw};
  endtask

  task automatic push_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // Mostly well-formed strings, some broken by a bad character, some pure noise.
  task automatic add_random_strings(input int n_items);
    logic [7:0] text[$];
    int         pushed;
    int         kind;
    int         n_groups;
    int         tail;
    int         i;
    pushed = 0;
    while (pushed < n_items) begin
      text.delete();
      kind = $urandom_range(9);
      if (kind < 8) begin
        n_groups = $urandom_range(3);
        tail     = $urandom_range(3);
        for (i = 0; i < 4 * n_groups + tail; i++)
          text = {text, char_of_sextet(6'($urandom_range(63)))};
        if (kind < 6) begin
          if (tail == 2) begin
            text = {text, PAD_CHAR};
            text = {text, PAD_CHAR};
          end else if (tail == 3) begin
            text = {text, PAD_CHAR};
          end
        end else begin
          text = {text, invalid_char()};
          repeat ($urandom_range(3)) text = {text, 8'($urandom_range(255))};
        end
      end else begin
        repeat ($urandom_range(1, 5)) text = {text, 8'($urandom_range(255))};
      end
      if (text.size() == 0) text = {text, char_of_sextet(6'($urandom_range(63)))};
      foreach (text[k]) push_char(text[k], k == text.size() - 1);
      pushed += text.size();
    end
  endtask

  // Driver: predict on acceptance, then load the next word or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid         <= 1'b0;
      in_if.char_code     <= '0;
      in_if.end_of_string <= 1'b0;
      dec_group  = '0;
      dec_count  = '0;
      dec_halted = 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        predict_bytes(in_if.char_code, in_if.end_of_string);
      if (!in_if.valid || in_if.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_char = pending_chars.pop_front();
          in_if.valid         <= 1'b1;
          in_if.char_code     <= next_char.char_code;
          in_if.end_of_string <= next_char.end_of_string;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    byte_word_t got;
    byte_word_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.data_byte, out_if.byte_valid, out_if.last};
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected word: byte=%02h valid=%0b last=%0b",
                     got.data_byte, got.byte_valid, got.last);
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected byte=%02h valid=%0b last=%0b",
                       want.data_byte, want.byte_valid, want.last,
                       ", got byte=%02h valid=%0b last=%0b",
                       got.data_byte, got.byte_valid, got.last);
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.char_code     = '0;
    in_if.end_of_string = 1'b0;
    out_if.ready        = 1'b0;
    tx_idle_pct         = 0;
    rx_stall_pct        = 0;
    mismatch_count      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full group; padding with characters ignored after the halt
    push_string("TWFu");
    push_string("AA==");
    // all-ones group, then a lone sextet that flushes nothing
    push_string("////A");
    // high code halts at once; the end item gives only a bare marker
    push_char(8'hFF, 1'b0);
    push_char(8'h7A, 1'b1);
    // code of 128 flushes one byte from two sextets
    push_char(8'h30, 1'b0);
    push_char(8'h39, 1'b0);
    push_char(8'h80, 1'b1);
    push_char(8'h00, 1'b1);
    push_string("aZ+");
    push_string("g=");

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      add_random_strings(40);
      // hold off the next phase until every result is back
      while (pending_chars.size() != 0 || in_if.valid || expected_bytes.size() != 0)
        @(negedge clk);
    end

    rx_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_bytes.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/b64sd_pkg.sv
rtl/b64sd_char_if.sv
rtl/b64sd_byte_if.sv
rtl/b64sd_front.sv
rtl/b64sd_fifo.sv
rtl/b64sd_back.sv
rtl/base64_stream_decoder.sv
tb/tb_base64_stream_decoder.sv
